@@ rtl/sks_pkg.sv @@
`default_nettype none
package sks_pkg;

  localparam int KEY_W   = 31;
  localparam int ACT_W   = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    logic               success;
    logic               store_full;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/sorted_key_set.sv @@
// Flow: from accept, the FSM reads and compares held keys one at a time (S_SRD, S_SCMP) from
// index 0 up to the insert position p, then decides in S_DEC; an add or remove that changes the
// set then moves entries (S_ARD/S_AWR or S_RRD/S_RWR), with at most one RAM read and write per state.
// One word is handled at a time; the next word is taken after the output loads.
// Reset (rst, synchronous): empties the set and clears control; key store is not cleared.
// A finished word waits in the output register while the next word is accepted.
`default_nettype none
module sorted_key_set #(
  parameter int CAPACITY = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  wire sks_pkg::req_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output sks_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SRD  = 8'b0000_0010,
    S_SCMP = 8'b0000_0100,
    S_DEC  = 8'b0000_1000,
    S_ARD  = 8'b0001_0000,
    S_AWR  = 8'b0010_0000,
    S_RRD  = 8'b0100_0000,
    S_RWR  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic hit, hit_next;
  logic ok, ok_next;
  logic full, full_next;
  logic fin, fin_next;
  sks_pkg::action_t act;
  logic [sks_pkg::KEY_W-1:0] key;

  logic [sks_pkg::KEY_W-1:0] mem [CAPACITY];
  logic [sks_pkg::KEY_W-1:0] rdata;
  logic [sks_pkg::KEY_W-1:0] wdata;
  logic [AW-1:0] raddr, waddr;
  logic we;

  logic [CW:0] idx_inc;
  logic lt, eq, out_free;

  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign lt       = rdata < key;
  assign eq       = rdata == key;
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && !fin;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    pos_next   = pos;
    hit_next   = hit;
    ok_next    = ok;
    full_next  = full;
    fin_next   = fin;
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wdata      = rdata;
    raddr      = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (fin) begin
          if (out_free) begin
            fin_next = 1'b0;
          end
        end else if (req_valid) begin
          idx_next  = '0;
          pos_next  = '0;
          hit_next  = 1'b0;
          ok_next   = 1'b0;
          full_next = 1'b0;
          state_next = (cnt == '0) ? S_DEC : S_SRD;
        end
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (lt && (idx_inc < {1'b0, cnt})) begin
          idx_next   = idx_inc[CW-1:0];
          state_next = S_SRD;
        end else begin
          pos_next   = lt ? idx_inc[CW-1:0] : idx;
          hit_next   = !lt && eq;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        fin_next   = 1'b1;
        case (act)
          sks_pkg::ACT_ADD: begin
            if (!hit) begin
              if (cnt == CW'(CAPACITY)) begin
                full_next = 1'b1;
              end else begin
                idx_next   = cnt;
                fin_next   = 1'b0;
                state_next = S_ARD;
              end
            end
          end
          sks_pkg::ACT_REMOVE: begin
            if (hit) begin
              idx_next   = pos;
              fin_next   = 1'b0;
              state_next = S_RRD;
            end
          end
          sks_pkg::ACT_CONTAINS: begin
            ok_next = hit;
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      S_ARD: begin
        if (idx == pos) begin
          we         = 1'b1;
          wdata      = key;
          cnt_next   = cnt + 1'b1;
          ok_next    = 1'b1;
          fin_next   = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr      = AW'(idx - 1'b1);
          state_next = S_AWR;
        end
      end
      S_AWR: begin
        we         = 1'b1;
        idx_next   = idx - 1'b1;
        state_next = S_ARD;
      end
      S_RRD: begin
        if (idx_inc >= {1'b0, cnt}) begin
          cnt_next   = cnt - 1'b1;
          ok_next    = 1'b1;
          fin_next   = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr      = idx_inc[AW-1:0];
          state_next = S_RWR;
        end
      end
      S_RWR: begin
        we         = 1'b1;
        idx_next   = idx_inc[CW-1:0];
        state_next = S_RRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      fin       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      fin   <= fin_next;
      if (state == S_IDLE && fin && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pos  <= pos_next;
    hit  <= hit_next;
    ok   <= ok_next;
    full <= full_next;
    if (req_valid && req_ready) begin
      act <= req.action;
      key <= req.key;
    end
    if (state == S_IDLE && fin && out_free) begin
      rsp.success     <= ok;
      rsp.store_full  <= full;
      rsp.entry_count <= sks_pkg::COUNT_W'(cnt);
    end
  end

endmodule
`default_nettype wire

@@ rtl/sks_checker.sv @@
`default_nettype none
module sks_checker #(
  parameter int CAPACITY = 64
) (
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_ready,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input wire sks_pkg::rsp_t rsp
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  a_full_fails: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.store_full) |-> !rsp.success)
    else $error("full word reports success");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.store_full) |-> (rsp.entry_count == sks_pkg::COUNT_W'(CAPACITY)))
    else $error("full word with count below capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 127 || rsp.entry_count <= sks_pkg::COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response word changed");

endmodule

bind sorted_key_set sks_checker #(.CAPACITY(CAPACITY)) u_sks_checker (.*);
`default_nettype wire

@@ dv/tb_sorted_key_set.sv @@
`default_nettype none
module tb_sorted_key_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_DEPTH   = 64;
  localparam int POOL_SIZE   = 96;
  localparam int RAND_WORDS  = 1225;
  localparam int PHASE_LEN   = 200;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    sks_pkg::req_t word;
    bit            typed;
    sks_pkg::rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sks_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sks_pkg::rsp_t rsp;

  sorted_key_set #(
    .CAPACITY (SET_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  logic [sks_pkg::KEY_W-1:0] model_keys [SET_DEPTH];
  int                        model_count = 0;
  logic [sks_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  plan_row_t                 plan [$];
  sks_pkg::rsp_t             status_q [$];

  int unsigned err_cnt     = 0;
  int unsigned sent_cnt    = 0;
  int unsigned seen_cnt    = 0;
  int unsigned full_cnt    = 0;
  int unsigned peak_count  = 0;
  int unsigned cycles      = 0;
  int          burst_left  = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          stall_mode  = 0;
  int          mode_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sorted_key_set: FAILED **");
      $finish;
    end
  end

  function automatic sks_pkg::rsp_t apply_set_op(sks_pkg::req_t w);
    sks_pkg::rsp_t r;
    int   pos;
    int   j;
    bit   hit;
    r   = '0;
    pos = 0;
    while (pos < model_count && model_keys[pos] < w.key) pos++;
    hit = (pos < model_count) && (model_keys[pos] == w.key);
    case (w.action)
      sks_pkg::ACT_ADD: begin
        if (!hit) begin
          if (model_count >= SET_DEPTH) begin
            r.store_full = 1'b1;
          end else begin
            for (j = model_count; j > pos; j--) model_keys[j] = model_keys[j-1];
            model_keys[pos] = w.key;
            model_count++;
            r.success = 1'b1;
          end
        end
      end
      sks_pkg::ACT_REMOVE: begin
        if (hit) begin
          for (j = pos; j + 1 < model_count; j++) model_keys[j] = model_keys[j+1];
          model_count--;
          r.success = 1'b1;
        end
      end
      sks_pkg::ACT_CONTAINS: r.success = hit;
      default: ;
    endcase
    r.entry_count = sks_pkg::COUNT_W'(model_count);
    return r;
  endfunction

  function automatic sks_pkg::req_t random_word(int idx);
    sks_pkg::req_t w;
    int   phase;
    int   ra;
    int   rk;
    int   add_w;
    int   rem_w;
    phase = (idx / PHASE_LEN) % 3;
    add_w = (phase == 0) ? 70 : (phase == 1) ? 40 : 12;
    rem_w = (phase == 0) ? 12 : (phase == 1) ? 30 : 70;
    ra = $urandom_range(0, 99);
    if (ra < add_w)              w.action = sks_pkg::ACT_ADD;
    else if (ra < add_w + rem_w) w.action = sks_pkg::ACT_REMOVE;
    else if (ra < 97)            w.action = sks_pkg::ACT_CONTAINS;
    else                         w.action = sks_pkg::ACT_NONE;
    rk = $urandom_range(0, 99);
    if (rk < 10)                          w.key = sks_pkg::KEY_W'($urandom);
    else if (rk < 30 && model_count > 0)  w.key = model_keys[$urandom_range(0, model_count - 1)];
    else                                  w.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return w;
  endfunction

  task automatic add_row(sks_pkg::action_t a, logic [sks_pkg::KEY_W-1:0] k, bit typed,
                         logic s, logic f, logic [sks_pkg::COUNT_W-1:0] n);
    plan_row_t row;
    row.word.action      = a;
    row.word.key         = k;
    row.typed            = typed;
    row.want.success     = s;
    row.want.store_full  = f;
    row.want.entry_count = n;
    plan.push_back(row);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(sks_pkg::req_t w, bit typed, sks_pkg::rsp_t typed_want);
    sks_pkg::rsp_t pred;
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pred = apply_set_op(w);
    if (pred.store_full) full_cnt++;
    if (model_count > peak_count) peak_count = model_count;
    status_q.push_back(typed ? typed_want : pred);
    sent_cnt++;
  endtask

  task automatic check_status(sks_pkg::rsp_t got);
    sks_pkg::rsp_t want;
    if (status_q.size() == 0) begin
      $error("status word with nothing pending: success %0b store_full %0b entry_count %0d",
             got.success, got.store_full, got.entry_count);
      err_cnt++;
      return;
    end
    want = status_q.pop_front();
    seen_cnt++;
    if (got.success !== want.success) begin
      $error("success: expected %0b, got %0b", want.success, got.success);
      err_cnt++;
    end
    if (got.store_full !== want.store_full) begin
      $error("store_full: expected %0b, got %0b", want.store_full, got.store_full);
      err_cnt++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_status(rsp);
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && seen_cnt >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= 1'($urandom_range(0, 1));
        2:       rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    foreach (key_pool[i]) key_pool[i] = sks_pkg::KEY_W'($urandom);
    for (int i = 4; i < 24; i++) key_pool[i] = sks_pkg::KEY_W'(i);
    key_pool[0] = '0;
    key_pool[1] = 31'h7FFF_FFFF;
    key_pool[2] = 31'h7FFF_FFFE;
    key_pool[3] = 31'd1;

    add_row(sks_pkg::ACT_CONTAINS, 31'h0000_0000, 1, 0, 0, 0);
    add_row(sks_pkg::ACT_REMOVE,   31'h7FFF_FFFE, 1, 0, 0, 0);
    add_row(sks_pkg::ACT_NONE,     31'h0000_0000, 1, 0, 0, 0);
    add_row(sks_pkg::ACT_ADD,      31'h7FFF_FFFE, 1, 1, 0, 1);
    add_row(sks_pkg::ACT_ADD,      31'h0000_0000, 1, 1, 0, 2);
    add_row(sks_pkg::ACT_ADD,      31'h0000_0000, 1, 0, 0, 2);
    add_row(sks_pkg::ACT_CONTAINS, 31'h7FFF_FFFF, 1, 0, 0, 2);
    add_row(sks_pkg::ACT_ADD,      31'h7FFF_FFFF, 1, 1, 0, 3);
    add_row(sks_pkg::ACT_CONTAINS, 31'h7FFF_FFFF, 1, 1, 0, 3);
    add_row(sks_pkg::ACT_NONE,     31'h7FFF_FFFF, 1, 0, 0, 3);
    add_row(sks_pkg::ACT_ADD,      31'h2AAA_AAAA, 1, 1, 0, 4);
    add_row(sks_pkg::ACT_ADD,      31'h5555_5555, 1, 1, 0, 5);
    add_row(sks_pkg::ACT_CONTAINS, 31'h2AAA_AAAA, 1, 1, 0, 5);
    add_row(sks_pkg::ACT_REMOVE,   31'h0000_0000, 1, 1, 0, 4);
    add_row(sks_pkg::ACT_REMOVE,   31'h0000_0000, 1, 0, 0, 4);
    add_row(sks_pkg::ACT_REMOVE,   31'h7FFF_FFFF, 1, 1, 0, 3);
    add_row(sks_pkg::ACT_ADD,      31'h0000_0001, 1, 1, 0, 4);
    add_row(sks_pkg::ACT_REMOVE,   31'h5555_5555, 1, 1, 0, 3);
    add_row(sks_pkg::ACT_CONTAINS, 31'h5555_5555, 1, 0, 0, 3);
    add_row(sks_pkg::ACT_ADD,      31'h4000_0000, 0, 0, 0, 0);
    add_row(sks_pkg::ACT_ADD,      31'h3FFF_FFFF, 0, 0, 0, 0);
    add_row(sks_pkg::ACT_CONTAINS, 31'h0000_0001, 0, 0, 0, 0);
    add_row(sks_pkg::ACT_NONE,     31'h0000_1234, 0, 0, 0, 0);
    add_row(sks_pkg::ACT_REMOVE,   31'h3FFF_FFFF, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      pace_sender();
      send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS / 2 && status_q.size() != 0) begin
        req_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
      end
      pace_sender();
      send_word(random_word(i), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d request words, checked %0d status words", sent_cnt, seen_cnt);
    $display("set filled to %0d keys, %0d adds refused as full", peak_count, full_cnt);
    if (err_cnt == 0 && status_q.size() == 0) begin
      $display("** sorted_key_set: PASSED **");
    end else begin
      $display("** sorted_key_set: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/sks_pkg.sv
rtl/sorted_key_set.sv
rtl/sks_checker.sv
dv/tb_sorted_key_set.sv
